### design/bsc_pkg.sv
// Package for the Banker's algorithm safety check block.
// Holds sizes, item types, codes and state encodings.
// Used by bsc_alu and bankers_safety_check_core; depends on nothing.
package bsc_pkg;

    localparam int MAX_PROC    = 8;
    localparam int MAX_RES     = 8;
    localparam int AMOUNT_BITS = 16;
    localparam int PIDX_W      = 3;
    localparam int RIDX_W      = 3;
    localparam int CNT_W       = 4;
    localparam int CFG_W       = 4;
    localparam int ADDR_W      = PIDX_W + RIDX_W;
    localparam int MEM_DEPTH   = MAX_PROC * MAX_RES;
    localparam int MEM_W       = 2 * AMOUNT_BITS;
    localparam int FREE_W      = AMOUNT_BITS + PIDX_W + 1;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [1:0] MODE_LOAD_ELEM  = 2'd0;
    localparam logic [1:0] MODE_LOAD_TOTAL = 2'd1;
    localparam logic [1:0] MODE_RUN        = 2'd2;

    localparam logic [1:0] KIND_GRANT  = 2'd0;
    localparam logic [1:0] KIND_SAFE   = 2'd1;
    localparam logic [1:0] KIND_UNSAFE = 2'd2;

    localparam logic REG_PROC_COUNT = 1'b0;
    localparam logic REG_RES_COUNT  = 1'b1;

    typedef struct packed {
        logic [1:0]             mode;
        logic [PIDX_W-1:0]      process_index;
        logic [RIDX_W-1:0]      resource_index;
        logic [AMOUNT_BITS-1:0] claim_amount;
        logic [AMOUNT_BITS-1:0] held_amount;
        logic [AMOUNT_BITS-1:0] total_amount;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PIDX_W-1:0] process_index_res;
        logic              last;
    } t_out_item;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_PROC,
        ST_CHK_RD,
        ST_CHK_CMP,
        ST_ADD_RD,
        ST_ADD_ACC,
        ST_GRANT
    } t_state;

endpackage

### design/bsc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; sized by its WIDTH and DEPTH parameters.
module bsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/bsc_alu.sv
// Shared signed adder and subtractor for the free vector arithmetic.
// Depends on bsc_pkg for widths and the operation type.
module bsc_alu import bsc_pkg::*; (
    input  t_alu_op                  i_op,
    input  logic signed [FREE_W-1:0] i_a,
    input  logic signed [FREE_W-1:0] i_b,
    output logic signed [FREE_W-1:0] o_sum
);

    always_comb begin
        unique case (i_op)
            ALU_ADD: o_sum = i_a + i_b;
            ALU_SUB: o_sum = i_a - i_b;
            default: o_sum = i_a;
        endcase
    end

endmodule

### design/bankers_safety_check_core.sv
// Top level of the Banker's algorithm safety check block.
// Depends on bsc_pkg, bsc_ram (claim and held store) and bsc_alu.
//
// Channel   Ports                                    Handshake
// command   start, busy, i_item                      taken when start and not busy
// result    o_res_strobe, o_res                      valid for one cycle, no stall
// config    psel, penable, pwrite, paddr, pwdata,    APB, pready tied high
//           prdata, pready
//
// A load item is written when taken and busy stays low. A run first forms the free
// vector (total minus held, a read and a subtract per element); each pass then steps
// through the processes, reads and compares each resource checked, adds the held
// amounts back on a grant; the single RAM read port and shared adder set this order.
// Reset is synchronous and active low; the stores keep their contents.
// Results cannot be stalled; each appears on the ports for exactly one cycle.
module bankers_safety_check_core import bsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    output logic              o_res_strobe,
    output t_out_item         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_proc_count, r_res_count;
    logic [CNT_W-1:0] r_n, r_m, r_i, r_j, r_done;
    logic [CNT_W-1:0] n_i, n_j, n_done;
    logic [CNT_W-1:0] sat_n, sat_m, i_inc, j_inc;
    logic             r_granted, n_granted;
    logic [MAX_PROC-1:0] r_finished, n_finished;
    logic signed [FREE_W-1:0] r_free [MAX_RES];
    logic signed [FREE_W-1:0] n_free [MAX_RES];
    logic [AMOUNT_BITS-1:0]   r_total [MAX_RES];
    logic             r_res_strobe, n_res_strobe;
    t_out_item        r_res, n_res;

    logic             accept, run_accept, cfg_wr, last_j, last_i, fits;
    logic [MEM_W-1:0] rd_data;
    logic [AMOUNT_BITS-1:0] rd_claim, rd_held;
    logic signed [FREE_W-1:0] alu_a, alu_b, alu_sum;
    t_alu_op          alu_op;

    assign accept     = start && !busy;
    assign run_accept = accept && (i_item.mode == MODE_RUN);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign busy       = (r_state != ST_IDLE);

    assign sat_n = (r_proc_count > CFG_W'(MAX_PROC)) ? CNT_W'(MAX_PROC) : r_proc_count;
    assign sat_m = (r_res_count > CFG_W'(MAX_RES)) ? CNT_W'(MAX_RES) : r_res_count;
    assign i_inc  = r_i + CNT_W'(1);
    assign j_inc  = r_j + CNT_W'(1);
    assign last_i = (i_inc == r_n);
    assign last_j = (j_inc == r_m);

    always_comb begin
        unique case (paddr[2])
            REG_PROC_COUNT: prdata = APB_DW'(r_proc_count);
            REG_RES_COUNT:  prdata = APB_DW'(r_res_count);
            default:        prdata = '0;
        endcase
    end

    bsc_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (i_item.mode == MODE_LOAD_ELEM)),
        .i_wr_addr ({i_item.process_index, i_item.resource_index}),
        .i_wr_data ({i_item.claim_amount, i_item.held_amount}),
        .i_rd_addr ({r_i[PIDX_W-1:0], r_j[RIDX_W-1:0]}),
        .o_rd_data (rd_data)
    );

    assign rd_claim = rd_data[MEM_W-1:AMOUNT_BITS];
    assign rd_held  = rd_data[AMOUNT_BITS-1:0];
    assign alu_a    = r_free[r_j[RIDX_W-1:0]];
    assign alu_b    = FREE_W'(rd_held);
    assign alu_op   = (r_state == ST_SUM_ACC) ? ALU_SUB : ALU_ADD;

    bsc_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_sum (alu_sum)
    );

    // Need fits free exactly when free plus held is at least the claim.
    assign fits = (alu_sum >= $signed(FREE_W'(rd_claim)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (run_accept) begin
                    n_state = (sat_n == '0 || sat_m == '0) ? ST_PROC : ST_SUM_RD;
                end
            end
            ST_SUM_RD:  n_state = ST_SUM_ACC;
            ST_SUM_ACC: n_state = (last_j && last_i) ? ST_PROC : ST_SUM_RD;
            ST_PROC: begin
                if (r_i == r_n) begin
                    if (r_done == r_n || !r_granted) begin
                        n_state = ST_IDLE;
                    end
                end else if (r_finished[r_i[PIDX_W-1:0]]) begin
                    n_state = ST_PROC;
                end else if (r_m == '0) begin
                    n_state = ST_GRANT;
                end else begin
                    n_state = ST_CHK_RD;
                end
            end
            ST_CHK_RD: n_state = ST_CHK_CMP;
            ST_CHK_CMP: begin
                if (!fits) begin
                    n_state = ST_PROC;
                end else if (last_j) begin
                    n_state = ST_ADD_RD;
                end else begin
                    n_state = ST_CHK_RD;
                end
            end
            ST_ADD_RD:  n_state = ST_ADD_ACC;
            ST_ADD_ACC: n_state = last_j ? ST_GRANT : ST_ADD_RD;
            ST_GRANT:   n_state = ST_PROC;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_i          = r_i;
        n_j          = r_j;
        n_done       = r_done;
        n_granted    = r_granted;
        n_finished   = r_finished;
        n_free       = r_free;
        n_res_strobe = 1'b0;
        n_res        = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (run_accept) begin
                    n_i        = '0;
                    n_j        = '0;
                    n_done     = '0;
                    n_granted  = 1'b0;
                    n_finished = '0;
                    for (int k = 0; k < MAX_RES; k++) begin
                        n_free[k] = FREE_W'(r_total[k]);
                    end
                end
            end
            ST_SUM_ACC: begin
                n_free[r_j[RIDX_W-1:0]] = alu_sum;
                if (last_j) begin
                    n_j = '0;
                    n_i = last_i ? '0 : i_inc;
                end else begin
                    n_j = j_inc;
                end
            end
            ST_PROC: begin
                if (r_i == r_n) begin
                    if (r_done == r_n) begin
                        n_res_strobe = 1'b1;
                        n_res        = '{kind: KIND_SAFE, process_index_res: '0, last: 1'b1};
                    end else if (!r_granted) begin
                        n_res_strobe = 1'b1;
                        n_res        = '{kind: KIND_UNSAFE, process_index_res: '0, last: 1'b1};
                    end else begin
                        n_i       = '0;
                        n_granted = 1'b0;
                    end
                end else if (r_finished[r_i[PIDX_W-1:0]]) begin
                    n_i = i_inc;
                end else begin
                    n_j = '0;
                end
            end
            ST_CHK_CMP: begin
                if (!fits) begin
                    n_i = i_inc;
                end else if (last_j) begin
                    n_j = '0;
                end else begin
                    n_j = j_inc;
                end
            end
            ST_ADD_ACC: begin
                n_free[r_j[RIDX_W-1:0]] = alu_sum;
                n_j = j_inc;
            end
            ST_GRANT: begin
                n_res_strobe = 1'b1;
                n_res        = '{kind: KIND_GRANT, process_index_res: r_i[PIDX_W-1:0],
                                 last: 1'b0};
                n_finished[r_i[PIDX_W-1:0]] = 1'b1;
                n_done    = r_done + CNT_W'(1);
                n_granted = 1'b1;
                n_i       = i_inc;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_proc_count <= CFG_W'(MAX_PROC);
            r_res_count  <= CFG_W'(MAX_RES);
            r_n          <= '0;
            r_m          <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_done       <= '0;
            r_granted    <= 1'b0;
            r_finished   <= '0;
            r_res_strobe <= 1'b0;
            for (int k = 0; k < MAX_RES; k++) begin
                r_free[k] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_i          <= n_i;
            r_j          <= n_j;
            r_done       <= n_done;
            r_granted    <= n_granted;
            r_finished   <= n_finished;
            r_res_strobe <= n_res_strobe;
            r_free       <= n_free;
            if (run_accept) begin
                r_n <= sat_n;
                r_m <= sat_m;
            end
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_PROC_COUNT: r_proc_count <= pwdata[CFG_W-1:0];
                    REG_RES_COUNT:  r_res_count  <= pwdata[CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept && (i_item.mode == MODE_LOAD_TOTAL)) begin
            r_total[i_item.resource_index] <= i_item.total_amount;
        end
    end

    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

    a_strobe_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(busy))
        else $error("result strobe without a run in progress");

    a_verdict_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.last) |-> !busy)
        else $error("verdict item shown while the run continues");

    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done <= r_n)
        else $error("more grants than processes");

    a_finished_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_finished >> r_n) == '0)
        else $error("finished flag set beyond the process count");

endmodule
